// ----- rtl/i2cmra_pkg.sv -----
`default_nettype none
package i2cmra_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_TXA     = 4'd2,
        PH_ACKA    = 4'd3,
        PH_TXR     = 4'd4,
        PH_ACKR    = 4'd5,
        PH_TXD     = 4'd6,
        PH_ACKD    = 4'd7,
        PH_RESTART = 4'd8,
        PH_TXB     = 4'd9,
        PH_ACKB    = 4'd10,
        PH_RX      = 4'd11,
        PH_RXACK   = 4'd12,
        PH_STOP    = 4'd13
    } phase_t;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] ADDR_BYTE_RESET = 8'd208;
    localparam logic [7:0] READ_BIT        = 8'h01;
    localparam logic [2:0] LAST_BIT        = 3'd7;
    localparam logic [1:0] TICK_HIGH       = 2'd1;
    localparam logic [1:0] TICK_LAST       = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] reg_address;
        logic [7:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       want_byte;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/i2cmra_fsm.sv -----
`default_nettype none
module i2cmra_fsm (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   step,
    input  wire i2cmra_pkg::item_t item,
    input  wire  [7:0]            addr_byte,
    output i2cmra_pkg::result_t   res
);
    import i2cmra_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] tick_reg, tick_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] reg_addr_reg, reg_addr_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       is_read_reg, is_read_next;
    logic       nack_reg, nack_next;

    // State as seen after a possible transaction start on this tick.
    logic       start_txn;
    phase_t     cur_phase;
    logic [1:0] cur_tick;
    logic [2:0] cur_bit;
    logic [7:0] cur_bytes;
    logic       cur_nack;

    logic [7:0] tx_src;
    logic [7:0] tx_word;
    logic [7:0] bytes_dec;
    logic       tick_last;

    assign start_txn = (phase_reg == PH_IDLE) &&
                       ((item.mode == MODE_WRITE) || (item.mode == MODE_READ));

    always_comb
    begin
        cur_phase     = phase_reg;
        cur_tick      = tick_reg;
        cur_bit       = bit_cnt_reg;
        cur_bytes     = bytes_left_reg;
        cur_nack      = nack_reg;
        is_read_next  = is_read_reg;
        reg_addr_next = reg_addr_reg;
        if (start_txn)
        begin
            cur_phase     = PH_START;
            cur_tick      = 2'd0;
            cur_bit       = 3'd0;
            cur_bytes     = item.length;
            cur_nack      = 1'b0;
            is_read_next  = (item.mode == MODE_READ);
            reg_addr_next = item.reg_address;
        end
    end

    always_comb
    begin
        case (cur_phase)
            PH_TXA:  tx_src = addr_byte;
            PH_TXR:  tx_src = reg_addr_reg;
            PH_TXD:  tx_src = item.write_byte;
            default: tx_src = addr_byte | READ_BIT;
        endcase
    end

    // A byte is loaded into the shifter on the first tick of its first bit.
    assign tx_word   = (cur_tick == 2'd0 && cur_bit == 3'd0) ? tx_src : shifter_reg;
    assign bytes_dec = cur_bytes - 8'd1;
    assign tick_last = (cur_tick >= TICK_LAST);

    // Next state.
    always_comb
    begin
        phase_next      = cur_phase;
        tick_next       = cur_tick;
        bit_cnt_next    = cur_bit;
        shifter_next    = shifter_reg;
        bytes_left_next = cur_bytes;
        nack_next       = cur_nack;
        case (cur_phase)
            PH_IDLE:
            begin
            end
            PH_START, PH_RESTART:
            begin
                if (cur_tick == TICK_HIGH)
                begin
                    phase_next   = (cur_phase == PH_START) ? PH_TXA : PH_TXB;
                    tick_next    = 2'd0;
                    bit_cnt_next = 3'd0;
                end
                else
                begin
                    tick_next = TICK_HIGH;
                end
            end
            PH_TXA, PH_TXR, PH_TXD, PH_TXB:
            begin
                shifter_next = tx_word;
                if (tick_last)
                begin
                    shifter_next = {tx_word[6:0], 1'b0};
                    tick_next    = 2'd0;
                    if (cur_bit >= LAST_BIT)
                    begin
                        bit_cnt_next = 3'd0;
                        case (cur_phase)
                            PH_TXA:  phase_next = PH_ACKA;
                            PH_TXR:  phase_next = PH_ACKR;
                            PH_TXD:  phase_next = PH_ACKD;
                            default: phase_next = PH_ACKB;
                        endcase
                    end
                    else
                    begin
                        bit_cnt_next = cur_bit + 3'd1;
                    end
                end
                else
                begin
                    tick_next = cur_tick + 2'd1;
                end
            end
            PH_ACKA, PH_ACKR, PH_ACKD, PH_ACKB:
            begin
                if (cur_tick == TICK_HIGH && item.sda_in)
                begin
                    nack_next = 1'b1;
                end
                if (tick_last)
                begin
                    tick_next    = 2'd0;
                    bit_cnt_next = 3'd0;
                    case (cur_phase)
                        PH_ACKA: phase_next = PH_TXR;
                        PH_ACKR:
                        begin
                            if (is_read_reg)
                                phase_next = PH_RESTART;
                            else
                                phase_next = (cur_bytes != 8'd0) ? PH_TXD : PH_STOP;
                        end
                        PH_ACKD:
                        begin
                            bytes_left_next = bytes_dec;
                            phase_next = (bytes_dec != 8'd0) ? PH_TXD : PH_STOP;
                        end
                        default: phase_next = (cur_bytes != 8'd0) ? PH_RX : PH_STOP;
                    endcase
                end
                else
                begin
                    tick_next = cur_tick + 2'd1;
                end
            end
            PH_RX:
            begin
                if (cur_tick == TICK_HIGH)
                begin
                    shifter_next = {shifter_reg[6:0], item.sda_in};
                end
                if (tick_last)
                begin
                    tick_next = 2'd0;
                    if (cur_bit >= LAST_BIT)
                    begin
                        bit_cnt_next = 3'd0;
                        phase_next   = PH_RXACK;
                    end
                    else
                    begin
                        bit_cnt_next = cur_bit + 3'd1;
                    end
                end
                else
                begin
                    tick_next = cur_tick + 2'd1;
                end
            end
            PH_RXACK:
            begin
                if (tick_last)
                begin
                    bytes_left_next = bytes_dec;
                    phase_next      = (bytes_dec != 8'd0) ? PH_RX : PH_STOP;
                    bit_cnt_next    = 3'd0;
                    tick_next       = 2'd0;
                end
                else
                begin
                    tick_next = cur_tick + 2'd1;
                end
            end
            PH_STOP:
            begin
                if (cur_tick == TICK_HIGH)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = 2'd0;
                end
                else
                begin
                    tick_next = TICK_HIGH;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                tick_next    = 2'd0;
                bit_cnt_next = 3'd0;
            end
        endcase
    end

    // Outputs for this tick.
    always_comb
    begin
        res            = '0;
        res.scl        = 1'b1;
        res.nack_seen  = nack_next;
        case (cur_phase)
            PH_IDLE:
            begin
            end
            PH_START, PH_RESTART:
            begin
                res.busy_res = 1'b1;
                res.sda_low  = (cur_tick == TICK_HIGH);
            end
            PH_TXA, PH_TXR, PH_TXD, PH_TXB:
            begin
                res.busy_res = 1'b1;
                res.scl      = (cur_tick == TICK_HIGH);
                res.sda_low  = ~tx_word[7];
            end
            PH_ACKA, PH_ACKR, PH_ACKD, PH_ACKB:
            begin
                res.busy_res  = 1'b1;
                res.scl       = (cur_tick == TICK_HIGH);
                res.want_byte = (phase_next == PH_TXD) && tick_last;
            end
            PH_RX:
            begin
                res.busy_res = 1'b1;
                res.scl      = (cur_tick == TICK_HIGH);
                if (tick_last && cur_bit >= LAST_BIT)
                begin
                    res.read_valid = 1'b1;
                    res.read_byte  = shifter_reg;
                end
            end
            PH_RXACK:
            begin
                res.busy_res = 1'b1;
                res.scl      = (cur_tick == TICK_HIGH);
                res.sda_low  = (cur_bytes > 8'd1);
            end
            PH_STOP:
            begin
                res.busy_res = 1'b1;
                res.scl      = (cur_tick == TICK_HIGH);
                res.sda_low  = 1'b1;
                res.done_res = (cur_tick == TICK_HIGH);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= 2'd0;
            bit_cnt_reg    <= 3'd0;
            shifter_reg    <= 8'd0;
            reg_addr_reg   <= 8'd0;
            bytes_left_reg <= 8'd0;
            is_read_reg    <= 1'b0;
            nack_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_cnt_reg    <= bit_cnt_next;
            shifter_reg    <= shifter_next;
            reg_addr_reg   <= reg_addr_next;
            bytes_left_reg <= bytes_left_next;
            is_read_reg    <= is_read_next;
            nack_reg       <= nack_next;
        end
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == PH_IDLE)
        else $error("stop finished but phase did not return to idle");

    a_read_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        res.read_valid |-> is_read_reg && phase_reg == PH_RX)
        else $error("read byte completed outside a read transaction");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= TICK_LAST)
        else $error("tick counter out of range");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(bytes_left_reg) && $stable(nack_reg))
        else $error("state changed without a tick");

    a_want_leads_txd: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.want_byte |=> phase_reg == PH_TXD)
        else $error("byte requested but no data byte follows");
`endif

endmodule
`default_nettype wire

// ----- rtl/i2c_master_register_access.sv -----
`default_nettype none
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     mode, reg_address, length, write_byte, sda_in
// out      output     out_valid / out_stall   scl, sda_low, want_byte, read_byte, read_valid,
//                                             nack_seen, busy_res, done_res
// cfg      input      cfg_valid / cfg_ready   address_byte
//
// Each input transfer is one bus timing tick and yields exactly one output transfer.
// One tick is taken per clock while the output is not stalled; its result passes through
// the input register, then the state machine step into the result register.
// Reset clears the state machine to idle, empties both registers and sets address_byte to 208.
// A stalled output holds the result register; the input side stalls only when both
// registers are full and the output is stalled.
module i2c_master_register_access (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [1:0] mode,
    input  wire  [7:0] reg_address,
    input  wire  [7:0] length,
    input  wire  [7:0] write_byte,
    input  wire        sda_in,
    output logic       out_valid,
    input  wire        out_stall,
    output logic       scl,
    output logic       sda_low,
    output logic       want_byte,
    output logic [7:0] read_byte,
    output logic       read_valid,
    output logic       nack_seen,
    output logic       busy_res,
    output logic       done_res,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [7:0] address_byte
);
    import i2cmra_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t step_result;
    logic [7:0] addr_byte_reg;
    logic    in_accept;
    logic    advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_byte_reg <= ADDR_BYTE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                addr_byte_reg <= address_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.mode        <= mode;
            item_reg.reg_address <= reg_address;
            item_reg.length      <= length;
            item_reg.write_byte  <= write_byte;
            item_reg.sda_in      <= sda_in;
        end
        if (advance)
            result_reg <= step_result;
    end

    i2cmra_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .addr_byte (addr_byte_reg),
        .res       (step_result)
    );

    assign out_valid  = out_valid_reg;
    assign scl        = result_reg.scl;
    assign sda_low    = result_reg.sda_low;
    assign want_byte  = result_reg.want_byte;
    assign read_byte  = result_reg.read_byte;
    assign read_valid = result_reg.read_valid;
    assign nack_seen  = result_reg.nack_seen;
    assign busy_res   = result_reg.busy_res;
    assign done_res   = result_reg.done_res;

endmodule
`default_nettype wire
